### hw/rtl/rgbc_pkg.sv
// ----------------------------------------------------------------------------
// RGBA convolution package
// Word types for the input and result channels, action and register codes,
// and the reset values of the configuration registers.
// ----------------------------------------------------------------------------
package rgbc_pkg;

  // Input word: one action with all of its possible operands.
  typedef struct packed {
    logic [1:0]         action;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [4:0]         coeff_index;
    logic signed [15:0] coeff_value;
    logic [7:0]         in_red;
    logic [7:0]         in_green;
    logic [7:0]         in_blue;
    logic [7:0]         in_alpha;
  } in_item_t;

  // Result word: one filtered pixel.
  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } out_item_t;

  // Action codes.
  localparam logic [1:0] ACT_PIXEL = 2'd0;
  localparam logic [1:0] ACT_COEFF = 2'd1;
  localparam logic [1:0] ACT_CONV  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_ALPHA  = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [6:0] RST_IMAGE_WIDTH   = 7'd64;
  localparam logic [6:0] RST_IMAGE_HEIGHT  = 7'd64;
  localparam logic [2:0] RST_KERNEL_WIDTH  = 3'd3;
  localparam logic [2:0] RST_KERNEL_HEIGHT = 3'd3;
  localparam logic       RST_FILTER_ALPHA  = 1'b1;

endpackage

### hw/rtl/rgba_convolution_2d_core.sv
// ----------------------------------------------------------------------------
// RGBA 2-D convolution core
// Frame store of RGBA8 pixels and kernel store of signed fixed-point
// coefficients; computes one filtered pixel per request, folding taps that
// fall outside the frame back into it.
// ----------------------------------------------------------------------------
//
//  Channel  Ports                                   Word
//  -------  --------------------------------------  --------------------------
//  input    in_valid / in_ready / in_data           action, position, operands
//  result   out_valid / out_ready / out_data        filtered RGBA pixel
//  config   cfg_valid / cfg_ready / cfg_index/data  one register write
//
// A compute walks the kernel one tap per cycle through a four-lane
// multiply-accumulate pipeline. in_ready is low from a compute's acceptance
// until its result is loaded into the output register; a stalled result
// holds the block in its last step. Configuration writes are taken every
// cycle. Reset is synchronous.
//
module rgba_convolution_2d_core
  import rgbc_pkg::*;
#(
  parameter int MAX_WIDTH       = 64,
  parameter int MAX_HEIGHT      = 64,
  parameter int MAX_KERNEL_SIDE = 5,
  parameter int COEFF_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Derived sizes.
  localparam int FDEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = $clog2(FDEPTH);
  localparam int KDEPTH = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
  localparam int KIW    = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
  localparam int KSW    = $clog2(MAX_KERNEL_SIDE + 1);
  localparam int XW     = $clog2(MAX_WIDTH);
  localparam int YW     = $clog2(MAX_HEIGHT);
  localparam int MAXDIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW     = ($clog2(MAXDIM + 1) > 7) ? $clog2(MAXDIM + 1) : 7;
  localparam int SXW    = CW + 2;
  localparam int PW     = 25;
  localparam int SUMW   = PW + KIW + 1;

  // Sequencer states.
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  // Fold a tap coordinate back into 0..size-1.
  function automatic logic signed [SXW-1:0] fold_coord(
    input logic signed [SXW-1:0] c,
    input logic signed [SXW-1:0] size
  );
    logic signed [SXW-1:0] a;
    logic signed [SXW-1:0] b;
    a = (c < 0) ? -c : c;
    b = (a >= size) ? ((size <<< 1) - SXW'(1) - a) : a;
    if (b < 0) begin
      b = '0;
    end else if (b >= size) begin
      b = size - SXW'(1);
    end
    return b;
  endfunction

  // Clamp a sum to 0..255 after dropping its fraction.
  function automatic logic [7:0] finish_sum(input logic signed [SUMW-1:0] s);
    logic [SUMW-1:0] v;
    v = $unsigned(s) >> COEFF_FRAC_BITS;
    if (s < 0) begin
      return 8'd0;
    end else if (v > SUMW'(255)) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  // Configuration registers.
  logic [6:0] cfg_iw_r;
  logic [6:0] cfg_ih_r;
  logic [2:0] cfg_kw_r;
  logic [2:0] cfg_kh_r;
  logic       cfg_fa_r;

  // Sequencer and per-compute operands.
  logic [1:0]   state_r;
  logic [1:0]   state_nxt;
  logic [CW-1:0] w_r;
  logic [CW-1:0] h_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [KSW-1:0] kw_r;
  logic [KSW-1:0] kh_r;
  logic [KSW-1:0] kx_r;
  logic [KSW-1:0] ky_r;
  logic [KIW-1:0] kidx_r;

  // Pipeline.
  logic                  v1_r, v2_r, v3_r;
  logic                  l1_r, l2_r, l3_r;
  logic [XW-1:0]         sx_r;
  logic [YW-1:0]         sy_r;
  logic [KIW-1:0]        kidx1_r;
  logic [31:0]           pix_r;
  logic signed [15:0]    coef_r;
  logic signed [PW-1:0]  prod_r [4];
  logic signed [SUMW-1:0] acc_r [4];

  // Stores.
  logic [31:0]        frame_mem_r  [FDEPTH];
  logic signed [15:0] kernel_mem_r [KDEPTH];

  // Output register.
  logic      out_valid_r;
  out_item_t out_data_r;

  // Combinational helpers.
  logic           in_accept;
  logic           out_free;
  logic           last_tap;
  logic [CW-1:0]  w_sat;
  logic [CW-1:0]  h_sat;
  logic [KSW-1:0] kw_sat;
  logic [KSW-1:0] kh_sat;
  logic signed [SXW-1:0] tap_x;
  logic signed [SXW-1:0] tap_y;
  logic signed [SXW-1:0] fold_x;
  logic signed [SXW-1:0] fold_y;
  logic [AW-1:0]  wr_addr;
  logic [AW-1:0]  rd_addr;
  logic           pix_in_range;
  logic           coeff_in_range;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_free  = !out_valid_r || out_ready;

  // Register values saturated into their legal ranges.
  always_comb begin
    if (32'(cfg_iw_r) < 32'd3) begin
      w_sat = CW'(3);
    end else if (32'(cfg_iw_r) > 32'(MAX_WIDTH)) begin
      w_sat = CW'(MAX_WIDTH);
    end else begin
      w_sat = CW'(cfg_iw_r);
    end
    if (32'(cfg_ih_r) < 32'd3) begin
      h_sat = CW'(3);
    end else if (32'(cfg_ih_r) > 32'(MAX_HEIGHT)) begin
      h_sat = CW'(MAX_HEIGHT);
    end else begin
      h_sat = CW'(cfg_ih_r);
    end
    if (cfg_kw_r == 3'd0) begin
      kw_sat = KSW'(1);
    end else if (32'(cfg_kw_r) > 32'(MAX_KERNEL_SIDE)) begin
      kw_sat = KSW'(MAX_KERNEL_SIDE);
    end else begin
      kw_sat = KSW'(cfg_kw_r);
    end
    if (cfg_kh_r == 3'd0) begin
      kh_sat = KSW'(1);
    end else if (32'(cfg_kh_r) > 32'(MAX_KERNEL_SIDE)) begin
      kh_sat = KSW'(MAX_KERNEL_SIDE);
    end else begin
      kh_sat = KSW'(cfg_kh_r);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_iw_r <= RST_IMAGE_WIDTH;
      cfg_ih_r <= RST_IMAGE_HEIGHT;
      cfg_kw_r <= RST_KERNEL_WIDTH;
      cfg_kh_r <= RST_KERNEL_HEIGHT;
      cfg_fa_r <= RST_FILTER_ALPHA;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:   cfg_iw_r <= cfg_data;
        CFG_IMAGE_HEIGHT:  cfg_ih_r <= cfg_data;
        CFG_KERNEL_WIDTH:  cfg_kw_r <= cfg_data[2:0];
        CFG_KERNEL_HEIGHT: cfg_kh_r <= cfg_data[2:0];
        CFG_FILTER_ALPHA:  cfg_fa_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Store writes and registered reads.
  assign pix_in_range   = (32'(in_data.pos_x) < 32'(MAX_WIDTH)) &&
                          (32'(in_data.pos_y) < 32'(MAX_HEIGHT));
  assign coeff_in_range = 32'(in_data.coeff_index) < 32'(KDEPTH);
  assign wr_addr = AW'(32'(in_data.pos_y) * MAX_WIDTH + 32'(in_data.pos_x));
  assign rd_addr = AW'(32'(sy_r) * MAX_WIDTH + 32'(sx_r));

  always_ff @(posedge clk) begin
    if (in_accept && in_data.action == ACT_PIXEL && pix_in_range) begin
      frame_mem_r[wr_addr] <= {in_data.in_alpha, in_data.in_blue,
                               in_data.in_green, in_data.in_red};
    end
    pix_r <= frame_mem_r[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (in_accept && in_data.action == ACT_COEFF && coeff_in_range) begin
      kernel_mem_r[KIW'(in_data.coeff_index)] <= in_data.coeff_value;
    end
    coef_r <= kernel_mem_r[kidx1_r];
  end

  // Tap position and border fold.
  assign tap_x  = signed'(SXW'(x_r)) - signed'(SXW'(kw_r >> 1)) + signed'(SXW'(kx_r));
  assign tap_y  = signed'(SXW'(y_r)) - signed'(SXW'(kh_r >> 1)) + signed'(SXW'(ky_r));
  assign fold_x = fold_coord(tap_x, signed'(SXW'(w_r)));
  assign fold_y = fold_coord(tap_y, signed'(SXW'(h_r)));
  assign last_tap = (kx_r == kw_r - KSW'(1)) && (ky_r == kh_r - KSW'(1));

  // Sequencer next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept && in_data.action == ACT_CONV) begin
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_tap) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (v3_r && l3_r) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      v1_r    <= (state_r == ST_RUN);
      v2_r    <= v1_r;
      v3_r    <= v2_r;
      if (state_r == ST_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Operand latch, tap counters and the multiply-accumulate pipeline.
  always_ff @(posedge clk) begin
    if (in_accept && in_data.action == ACT_CONV) begin
      w_r    <= w_sat;
      h_r    <= h_sat;
      kw_r   <= kw_sat;
      kh_r   <= kh_sat;
      x_r    <= XW'((CW'(in_data.pos_x) >= w_sat) ? w_sat - CW'(1)
                                                  : CW'(in_data.pos_x));
      y_r    <= YW'((CW'(in_data.pos_y) >= h_sat) ? h_sat - CW'(1)
                                                  : CW'(in_data.pos_y));
      kx_r   <= '0;
      ky_r   <= '0;
      kidx_r <= '0;
      for (int i = 0; i < 4; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      if (state_r == ST_RUN) begin
        kidx_r <= kidx_r + KIW'(1);
        if (kx_r == kw_r - KSW'(1)) begin
          kx_r <= '0;
          ky_r <= ky_r + KSW'(1);
        end else begin
          kx_r <= kx_r + KSW'(1);
        end
      end
      if (v3_r) begin
        for (int i = 0; i < 4; i++) begin
          acc_r[i] <= acc_r[i] + SUMW'(prod_r[i]);
        end
      end
    end

    // Stage one: folded tap coordinates and kernel index.
    sx_r    <= XW'(fold_x);
    sy_r    <= YW'(fold_y);
    kidx1_r <= kidx_r;
    l1_r    <= last_tap;
    l2_r    <= l1_r;
    l3_r    <= l2_r;

    // Stage three: one product per channel.
    for (int i = 0; i < 4; i++) begin
      prod_r[i] <= PW'(signed'({1'b0, pix_r[8*i +: 8]})) * PW'(coef_r);
    end

    // Result word.
    if (state_r == ST_FIN && out_free) begin
      out_data_r.out_red   <= finish_sum(acc_r[0]);
      out_data_r.out_green <= finish_sum(acc_r[1]);
      out_data_r.out_blue  <= finish_sum(acc_r[2]);
      out_data_r.out_alpha <= cfg_fa_r ? finish_sum(acc_r[3]) : 8'd255;
    end
  end

endmodule

### test/rgba_convolution_2d_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGBA convolution core testbench
// Loads pixels and coefficients, requests filtered pixels under several frame
// and kernel settings, and checks every result word against a local model of
// the folded-border convolution. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module rgba_convolution_2d_core_test;
  import rgbc_pkg::*;

  localparam int MAX_W        = 64;
  localparam int MAX_H        = 64;
  localparam int MAX_SIDE     = 5;
  localparam int KERNEL_TAPS  = MAX_SIDE * MAX_SIDE;
  localparam int FRAC_BITS    = 12;
  localparam int DRAIN_CYCLES = KERNEL_TAPS + 12;
  localparam int LONG_HOLD    = 200;

  // Action code the block does not use, and a register index with no register.
  localparam logic [1:0]           ACT_NONE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  rgba_convolution_2d_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Local copy of the block's registers and stores.
  logic [6:0]      img_w_reg    = RST_IMAGE_WIDTH;
  logic [6:0]      img_h_reg    = RST_IMAGE_HEIGHT;
  logic [2:0]      ker_w_reg    = RST_KERNEL_WIDTH;
  logic [2:0]      ker_h_reg    = RST_KERNEL_HEIGHT;
  logic            alpha_en_reg = RST_FILTER_ALPHA;
  logic [3:0][7:0] frame_mem [MAX_W*MAX_H];
  logic signed [15:0] kernel_mem [KERNEL_TAPS];

  // Words waiting to be sent, and filtered pixels waiting to come back.
  in_item_t  word_backlog [$];
  out_item_t pixel_expect [$];

  // Append one word to the send backlog.
  function automatic void enqueue_word(in_item_t w);
    word_backlog.insert(word_backlog.size(), w);
  endfunction

  // Which entries the stimulus has already written.
  bit pix_seen  [MAX_W*MAX_H];
  bit coef_seen [KERNEL_TAPS];
  int last_x = 0;
  int last_y = 0;

  int error_count  = 0;
  int results_seen = 0;
  int tx_wait      = 0;
  int rx_stall     = 0;
  bit tx_fast      = 1'b0;
  bit rx_fast      = 1'b0;

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int eff_w();
    return clamp_int(int'(img_w_reg), 3, MAX_W);
  endfunction

  function automatic int eff_h();
    return clamp_int(int'(img_h_reg), 3, MAX_H);
  endfunction

  function automatic int eff_kw();
    return clamp_int(int'(ker_w_reg), 1, MAX_SIDE);
  endfunction

  function automatic int eff_kh();
    return clamp_int(int'(ker_h_reg), 1, MAX_SIDE);
  endfunction

  // Mirror a tap coordinate back into 0..size-1.
  function automatic int fold_tap(int c, int size);
    if (c < 0) c = -c;
    if (c >= size) c = 2 * size - 1 - c;
    return clamp_int(c, 0, size - 1);
  endfunction

  // Drop the fraction of a channel sum and clamp it to a byte.
  function automatic logic [7:0] channel_byte(longint s);
    longint v;
    if (s < 0) return 8'd0;
    v = s >>> FRAC_BITS;
    if (v > 255) return 8'd255;
    return 8'(v);
  endfunction

  function automatic out_item_t conv_pixel(in_item_t w);
    int              fw, fh, kw, kh, x, y, kx, ky, sx, sy, ch;
    longint          acc [4];
    logic [3:0][7:0] px;
    out_item_t       res;
    fw = eff_w();
    fh = eff_h();
    kw = eff_kw();
    kh = eff_kh();
    x  = clamp_int(int'(w.pos_x), 0, fw - 1);
    y  = clamp_int(int'(w.pos_y), 0, fh - 1);
    for (ch = 0; ch < 4; ch++) acc[ch] = 0;
    for (ky = 0; ky < kh; ky++) begin
      for (kx = 0; kx < kw; kx++) begin
        sx = fold_tap(x - kw / 2 + kx, fw);
        sy = fold_tap(y - kh / 2 + ky, fh);
        px = frame_mem[sy * MAX_W + sx];
        for (ch = 0; ch < 4; ch++) begin
          acc[ch] += longint'(px[ch]) * longint'(kernel_mem[ky * kw + kx]);
        end
      end
    end
    res.out_red   = channel_byte(acc[0]);
    res.out_green = channel_byte(acc[1]);
    res.out_blue  = channel_byte(acc[2]);
    res.out_alpha = alpha_en_reg ? channel_byte(acc[3]) : 8'hFF;
    return res;
  endfunction

  // Apply one accepted word to the local stores.
  function automatic void absorb_word(in_item_t w);
    case (w.action)
      ACT_PIXEL: frame_mem[{w.pos_y, w.pos_x}] = {w.in_alpha, w.in_blue, w.in_green, w.in_red};
      ACT_COEFF: if (w.coeff_index < KERNEL_TAPS) kernel_mem[w.coeff_index] = w.coeff_value;
      ACT_CONV:  pixel_expect.insert(pixel_expect.size(), conv_pixel(w));
      default: ;
    endcase
  endfunction

  function automatic int draw_idle(bit fast);
    return fast ? 0 : $urandom_range(0, 6);
  endfunction

  // Input driver: one word per handshake, with a random gap after each.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_wait = 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_word(in_data);
        if ($urandom_range(0, 24) == 0) tx_fast = !tx_fast;
        tx_wait = draw_idle(tx_fast);
      end
      if (!in_valid || in_ready) begin
        if (tx_wait > 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (word_backlog.size() != 0) begin
          in_data  <= word_backlog.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each word with the oldest expectation, then stall.
  out_item_t want_pixel;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pixel_expect.size() == 0) begin
          $error("result word with no request outstanding: %h", out_data);
          error_count++;
        end else begin
          want_pixel = pixel_expect.pop_front();
          if (out_data.out_red !== want_pixel.out_red) begin
            $error("out_red: expected %0d, got %0d", want_pixel.out_red, out_data.out_red);
            error_count++;
          end
          if (out_data.out_green !== want_pixel.out_green) begin
            $error("out_green: expected %0d, got %0d", want_pixel.out_green,
                   out_data.out_green);
            error_count++;
          end
          if (out_data.out_blue !== want_pixel.out_blue) begin
            $error("out_blue: expected %0d, got %0d", want_pixel.out_blue, out_data.out_blue);
            error_count++;
          end
          if (out_data.out_alpha !== want_pixel.out_alpha) begin
            $error("out_alpha: expected %0d, got %0d", want_pixel.out_alpha,
                   out_data.out_alpha);
            error_count++;
          end
        end
        results_seen++;
        if ($urandom_range(0, 24) == 0) rx_fast = !rx_fast;
        // A long hold now and then lets the sender back up behind the block.
        if (results_seen == 12 || results_seen == 45) rx_stall = LONG_HOLD;
        else rx_stall = draw_idle(rx_fast);
      end else if (rx_stall > 0) begin
        rx_stall--;
      end
      out_ready <= (rx_stall == 0);
    end
  end

  // Word builders: every field starts random, then the action's fields are set.
  function automatic in_item_t rand_word(logic [1:0] act);
    in_item_t w;
    w.action      = act;
    w.pos_x       = 6'($urandom);
    w.pos_y       = 6'($urandom);
    w.coeff_index = 5'($urandom);
    w.coeff_value = 16'($urandom);
    w.in_red      = 8'($urandom);
    w.in_green    = 8'($urandom);
    w.in_blue     = 8'($urandom);
    w.in_alpha    = 8'($urandom);
    return w;
  endfunction

  function automatic void queue_pixel(int x, int y, logic [31:0] rgba);
    in_item_t w;
    w          = rand_word(ACT_PIXEL);
    w.pos_x    = 6'(x);
    w.pos_y    = 6'(y);
    w.in_red   = rgba[31:24];
    w.in_green = rgba[23:16];
    w.in_blue  = rgba[15:8];
    w.in_alpha = rgba[7:0];
    pix_seen[y * MAX_W + x] = 1'b1;
    enqueue_word(w);
  endfunction

  function automatic void queue_coeff(int idx, int val);
    in_item_t w;
    w             = rand_word(ACT_COEFF);
    w.coeff_index = 5'(idx);
    w.coeff_value = 16'(val);
    if (idx < KERNEL_TAPS) coef_seen[idx] = 1'b1;
    enqueue_word(w);
  endfunction

  // Coefficient mostly scaled so the sums land inside the byte range.
  function automatic int rand_coef();
    int lim;
    lim = 12288 / (eff_kw() * eff_kh());
    case ($urandom_range(0, 9))
      0:       return $signed(16'($urandom));
      1:       return -int'($urandom_range(0, lim / 2));
      default: return $urandom_range(0, lim);
    endcase
  endfunction

  // Fill every tap the request will read that is still unwritten, then ask.
  function automatic void queue_conv(int x_req, int y_req);
    int fw, fh, kw, kh, x, y, kx, ky, sx, sy;
    in_item_t w;
    fw = eff_w();
    fh = eff_h();
    kw = eff_kw();
    kh = eff_kh();
    x  = clamp_int(x_req, 0, fw - 1);
    y  = clamp_int(y_req, 0, fh - 1);
    for (ky = 0; ky < kh; ky++) begin
      for (kx = 0; kx < kw; kx++) begin
        if (!coef_seen[ky * kw + kx]) queue_coeff(ky * kw + kx, rand_coef());
        sx = fold_tap(x - kw / 2 + kx, fw);
        sy = fold_tap(y - kh / 2 + ky, fh);
        if (!pix_seen[sy * MAX_W + sx]) queue_pixel(sx, sy, $urandom);
      end
    end
    w       = rand_word(ACT_CONV);
    w.pos_x = 6'(x_req);
    w.pos_y = 6'(y_req);
    last_x  = x;
    last_y  = y;
    enqueue_word(w);
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_IMAGE_WIDTH:   img_w_reg    = 7'(val);
      CFG_IMAGE_HEIGHT:  img_h_reg    = 7'(val);
      CFG_KERNEL_WIDTH:  ker_w_reg    = 3'(val);
      CFG_KERNEL_HEIGHT: ker_h_reg    = 3'(val);
      CFG_FILTER_ALPHA:  alpha_en_reg = 1'(val);
      default: ;
    endcase
  endtask

  task automatic set_config(input int w, input int h, input int kw, input int kh,
                            input int alpha);
    write_reg(CFG_IMAGE_WIDTH, w);
    write_reg(CFG_IMAGE_HEIGHT, h);
    write_reg(CFG_KERNEL_WIDTH, kw);
    write_reg(CFG_KERNEL_HEIGHT, kh);
    write_reg(CFG_FILTER_ALPHA, alpha);
  endtask

  // Wait until nothing is queued or outstanding, then let the pipeline drain.
  task automatic wait_idle();
    do @(negedge clk);
    while (word_backlog.size() != 0 || in_valid || pixel_expect.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random traffic, mostly requests around recently used spots.
  task automatic run_random(input int decisions);
    int n, pick, k, taps;
    @(negedge clk);
    for (n = 0; n < decisions; n++) begin
      pick = $urandom_range(0, 99);
      taps = eff_kw() * eff_kh();
      if (pick < 5) begin
        queue_conv($urandom_range(0, 63), $urandom_range(0, 63));
      end else if (pick < 50) begin
        if ($urandom_range(0, 3) == 0)
          queue_conv($urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1));
        else
          queue_conv(clamp_int(last_x + $urandom_range(0, 4) - 2, 0, eff_w() - 1),
                     clamp_int(last_y + $urandom_range(0, 4) - 2, 0, eff_h() - 1));
      end else if (pick < 70) begin
        if (pick < 66) queue_pixel($urandom_range(0, eff_w() - 1),
                                   $urandom_range(0, eff_h() - 1), $urandom);
        else queue_pixel($urandom_range(0, 63), $urandom_range(0, 63), $urandom);
      end else if (pick < 88) begin
        if (pick < 85) queue_coeff($urandom_range(0, taps - 1), rand_coef());
        else queue_coeff($urandom_range(0, 31), rand_coef());
      end else if (pick < 95) begin
        enqueue_word(rand_word(ACT_NONE));
      end else begin
        // Fresh kernel followed by a request.
        for (k = 0; k < taps; k++) queue_coeff(k, rand_coef());
        queue_conv($urandom_range(0, eff_w() - 1), $urandom_range(0, eff_h() - 1));
      end
    end
    wait_idle();
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed words under the reset settings: identity kernel at both
    // corners, extreme coefficients, and words the block must ignore.
    @(negedge clk);
    for (int k = 0; k < 9; k++) queue_coeff(k, (k == 4) ? 4096 : 0);
    queue_pixel(0, 0, 32'hFF00FF00);
    queue_conv(0, 0);
    queue_conv(63, 63);
    queue_coeff(0, -32768);
    queue_coeff(8, 32767);
    queue_pixel(1, 1, 32'h00FF00FF);
    queue_conv(0, 0);
    queue_conv(62, 62);
    queue_coeff(31, $urandom);
    enqueue_word(rand_word(ACT_NONE));
    queue_conv(1, 1);
    wait_idle();

    // Smallest frame with the largest kernel.
    set_config(3, 3, 5, 5, 1);
    run_random(24);

    // Single tap, alpha forced.
    set_config(8, 5, 1, 1, 0);
    run_random(20);

    // Full frame, wide and flat kernel.
    set_config(64, 64, 5, 2, 1);
    run_random(24);

    // Register values outside their ranges saturate; unused index is harmless.
    set_config(0, 127, 0, 7, 0);
    write_reg(CFG_SPARE, $urandom);
    run_random(20);
    set_config(127, 0, 7'h7A, 7'h79, 7'h7F);
    run_random(18);

    // Random settings.
    repeat (3) begin
      set_config($urandom_range(3, 16), $urandom_range(3, 16), $urandom_range(1, 5),
                 $urandom_range(1, 5), $urandom_range(0, 1));
      run_random(20);
    end

    if (error_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hw/rtl/rgbc_pkg.sv
hw/rtl/rgba_convolution_2d_core.sv
test/rgba_convolution_2d_core_test.sv
